/* design/dssu_pkg.sv */
// Shared types, sizes and operation codes for the data stack shuffle unit.
package dssu_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int WORD_WIDTH  = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int FUNC_W      = 4;
    localparam int STATUS_W    = 2;

    // Entries below the top three live in a small RAM
    localparam int MEM_DEPTH = (STACK_DEPTH > 4) ? STACK_DEPTH - 3 : 2;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    localparam logic [FUNC_W-1:0] FUNC_PUSH     = 4'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 4'd1;
    localparam logic [FUNC_W-1:0] FUNC_DUP      = 4'd2;
    localparam logic [FUNC_W-1:0] FUNC_DUPD     = 4'd3;
    localparam logic [FUNC_W-1:0] FUNC_POP      = 4'd4;
    localparam logic [FUNC_W-1:0] FUNC_POPD     = 4'd5;
    localparam logic [FUNC_W-1:0] FUNC_POP2     = 4'd6;
    localparam logic [FUNC_W-1:0] FUNC_SWAP     = 4'd7;
    localparam logic [FUNC_W-1:0] FUNC_SWAPD    = 4'd8;
    localparam logic [FUNC_W-1:0] FUNC_ROTATE   = 4'd9;
    localparam logic [FUNC_W-1:0] FUNC_ROLLUP   = 4'd10;
    localparam logic [FUNC_W-1:0] FUNC_ROLLDOWN = 4'd11;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_FEW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    typedef logic [WORD_WIDTH-1:0] word_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        word_t             value;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    depth;
        word_t               top0;
        word_t               top1;
        word_t               top2;
    } rsp_t;

endpackage

/* design/data_stack_shuffle_unit_top.sv */
// The response is registered: a cmd transfer's rsp is offered in the next cycle.
// Throughput: one op per cycle unless cmd_stall; the top three entries sit
// in flops and the two entries below them are prefetched from the spill RAM.
// Reset: rst_n (asynchronous, active low) empties the stack and drops any
// pending response; the spill RAM needs no clearing pass.
// Top level: data stack with a cached top of stack and a spill RAM.
module data_stack_shuffle_unit_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  dssu_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output dssu_pkg::rsp_t rsp
);
    import dssu_pkg::*;

    // Stack layout: entry i from the top.
    //   i = 0..2 : top0_reg..top2_reg
    //   i = 3    : below0_reg (copy of RAM entry count-4)
    //   i = 4    : below1_reg (copy of RAM entry count-5)
    //   i >= 3   : also held in spill_mem at absolute index count-1-i
    // Growing ops spill top2 into the RAM; shrinking ops refill the cache
    // from below0/below1 and fetch the next two RAM entries. A cycle never
    // both writes and reads the RAM, so no bypass is needed.
    word_t            spill_mem [MEM_DEPTH];

    logic [CNT_W-1:0] count_reg, count_next;
    word_t            top0_reg, top1_reg, top2_reg;
    word_t            top0_next, top1_next, top2_next;
    word_t            below0_reg, below1_reg;
    word_t            below0_next, below1_next;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    logic             accept;
    logic [1:0]       need;
    logic             grows;
    logic             shrink1, shrink2;
    logic [STATUS_W-1:0] status;
    logic             exec;
    logic             spill;
    logic [CNT_W-1:0] spill_idx, rd_idx0, rd_idx1;
    logic [MEM_AW-1:0] spill_addr, rd_addr0, rd_addr1;

    // Hold the command while an untaken response blocks the output register
    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;

    // Decode how many entries the op needs and whether it grows the stack
    always_comb
    begin
        need  = 2'd0;
        grows = 1'b0;
        unique case (cmd.func) inside
            FUNC_PUSH:                   grows = 1'b1;
            FUNC_DUP:
            begin
                need  = 2'd1;
                grows = 1'b1;
            end
            FUNC_DUPD:
            begin
                need  = 2'd2;
                grows = 1'b1;
            end
            FUNC_POP:                    need = 2'd1;
            FUNC_POPD, FUNC_POP2, FUNC_SWAP: need = 2'd2;
            FUNC_SWAPD, FUNC_ROTATE, FUNC_ROLLUP, FUNC_ROLLDOWN: need = 2'd3;
            default:                     need = 2'd0;
        endcase
    end

    // Argument check first, then the full-stack check
    always_comb
    begin
        if (count_reg < CNT_W'(need))
        begin
            status = STATUS_TOO_FEW;
        end
        else if (grows && (count_reg >= CNT_W'(STACK_DEPTH)))
        begin
            status = STATUS_OVERFLOW;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    assign exec = (status == STATUS_OK);

    // RAM addresses: spill slot for a growing op, and the two entries that
    // become below0/below1 after a shrink (count-6 and count-7).
    assign spill_idx  = count_reg - CNT_W'(3);
    assign rd_idx0    = count_reg - CNT_W'(6);
    assign rd_idx1    = count_reg - CNT_W'(7);
    assign spill_addr = spill_idx[MEM_AW-1:0];
    assign rd_addr0   = rd_idx0[MEM_AW-1:0];
    assign rd_addr1   = rd_idx1[MEM_AW-1:0];

    // Next cached entries and depth for the accepted op
    always_comb
    begin
        count_next = count_reg;
        top0_next  = top0_reg;
        top1_next  = top1_reg;
        top2_next  = top2_reg;
        shrink1    = 1'b0;
        shrink2    = 1'b0;
        if (exec)
        begin
            case (cmd.func)
                FUNC_PUSH:
                begin
                    top0_next  = cmd.value;
                    top1_next  = top0_reg;
                    top2_next  = top1_reg;
                    count_next = count_reg + CNT_W'(1);
                end
                FUNC_CLEAR:
                begin
                    count_next = '0;
                end
                FUNC_DUP:
                begin
                    top1_next  = top0_reg;
                    top2_next  = top1_reg;
                    count_next = count_reg + CNT_W'(1);
                end
                FUNC_DUPD:
                begin
                    top2_next  = top1_reg;
                    count_next = count_reg + CNT_W'(1);
                end
                FUNC_POP:
                begin
                    top0_next  = top1_reg;
                    top1_next  = top2_reg;
                    top2_next  = below0_reg;
                    count_next = count_reg - CNT_W'(1);
                    shrink1    = 1'b1;
                end
                FUNC_POPD:
                begin
                    top1_next  = top2_reg;
                    top2_next  = below0_reg;
                    count_next = count_reg - CNT_W'(1);
                    shrink1    = 1'b1;
                end
                FUNC_POP2:
                begin
                    top0_next  = top2_reg;
                    top1_next  = below0_reg;
                    top2_next  = below1_reg;
                    count_next = count_reg - CNT_W'(2);
                    shrink2    = 1'b1;
                end
                FUNC_SWAP:
                begin
                    top0_next = top1_reg;
                    top1_next = top0_reg;
                end
                FUNC_SWAPD:
                begin
                    top1_next = top2_reg;
                    top2_next = top1_reg;
                end
                FUNC_ROTATE:
                begin
                    top0_next = top2_reg;
                    top2_next = top0_reg;
                end
                FUNC_ROLLUP:
                begin
                    top0_next = top1_reg;
                    top1_next = top2_reg;
                    top2_next = top0_reg;
                end
                FUNC_ROLLDOWN:
                begin
                    top0_next = top2_reg;
                    top1_next = top0_reg;
                    top2_next = top1_reg;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // Spill top2 on growth once it holds a live entry
    assign spill = accept && exec && grows && (count_reg >= CNT_W'(3));

    // On growth the old top2 becomes entry 3; below0 slides to entry 4.
    // Shrinks take RAM data in the clocked block below.
    always_comb
    begin
        below0_next = below0_reg;
        below1_next = below1_reg;
        if (exec && grows)
        begin
            below0_next = top2_reg;
            below1_next = below0_reg;
        end
    end

    // Spill RAM and prefetch registers; contents need no reset
    always_ff @(posedge clk)
    begin
        if (spill)
        begin
            spill_mem[spill_addr] <= top2_reg;
        end
        if (accept)
        begin
            if (shrink1)
            begin
                below0_reg <= below1_reg;
                below1_reg <= spill_mem[rd_addr0];
            end
            else if (shrink2)
            begin
                below0_reg <= spill_mem[rd_addr0];
                below1_reg <= spill_mem[rd_addr1];
            end
            else
            begin
                below0_reg <= below0_next;
                below1_reg <= below1_next;
            end
        end
    end

    // Cached top entries: payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top0_reg <= top0_next;
            top1_reg <= top1_next;
            top2_reg <= top2_next;
        end
    end

    // Depth and response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Response register: absent entries read as zero
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_reg.status <= status;
            rsp_reg.depth  <= count_next;
            rsp_reg.top0   <= (count_next >= CNT_W'(1)) ? top0_next : '0;
            rsp_reg.top1   <= (count_next >= CNT_W'(2)) ? top1_next : '0;
            rsp_reg.top2   <= (count_next >= CNT_W'(3)) ? top2_next : '0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

/* bench/data_stack_shuffle_unit_top_tb.sv */
// Testbench for the data stack shuffle unit: directed table, then random operation streams.
`timescale 1ns / 100ps

module data_stack_shuffle_unit_top_tb;
    import dssu_pkg::*;

    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_OPS   = 1420;
    // Random operations in this window run with no idling on either side
    localparam int QUIET_FIRST  = 500;
    localparam int QUIET_LAST   = 800;
    localparam int IDLE_PERCENT = 16;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int REPORT_LIMIT = 10;

    // Codes above the last shuffle decode to no operation
    localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 4'd12;
    localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 4'd15;

    // Bias of the random stream: push the stack toward full, toward empty, or neither
    typedef enum int {MODE_GROW, MODE_SHRINK, MODE_MIXED} drift_t;

    // One row of the directed table; typed rows carry their response by hand
    typedef struct {
        logic [FUNC_W-1:0] func;
        word_t             value;
        int                reps;
        bit                typed;
        rsp_t              want;
    } dir_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Shadow copy of the stack; index 0 is the bottom entry
    word_t shadow_stack [STACK_DEPTH];
    int    shadow_depth = 0;

    rsp_t     expected_rsp_q [$];
    dir_row_t dir_rows [$];
    int       mismatches = 0;
    int       cycles     = 0;
    bit       quiet      = 1'b0;

    data_stack_shuffle_unit_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    // Entry i places below the top of the shadow stack, zero if absent
    function automatic word_t shadow_entry(input int i);
        return (i < shadow_depth) ? shadow_stack[shadow_depth - 1 - i] : '0;
    endfunction

    // Apply one operation to the shadow stack and return the response it must give
    function automatic rsp_t apply_stack_op(input cmd_t c);
        rsp_t  r;
        int    need;
        bit    grows;
        int    n;
        word_t x, y, z;
        n = shadow_depth;
        case (c.func) inside
            FUNC_DUP, FUNC_POP: need = 1;
            FUNC_DUPD, FUNC_POPD, FUNC_POP2, FUNC_SWAP: need = 2;
            FUNC_SWAPD, FUNC_ROTATE, FUNC_ROLLUP, FUNC_ROLLDOWN: need = 3;
            default: need = 0;
        endcase
        grows = (c.func == FUNC_PUSH) || (c.func == FUNC_DUP) || (c.func == FUNC_DUPD);
        r = '0;
        r.status = STATUS_OK;
        // The argument check wins over the full-stack check
        if (n < need)
        begin
            r.status = STATUS_TOO_FEW;
        end
        else if (grows && n >= STACK_DEPTH)
        begin
            r.status = STATUS_OVERFLOW;
        end
        else
        begin
            // x y z are the third, second and top entries where they exist
            x = (n >= 3) ? shadow_stack[n - 3] : '0;
            y = (n >= 2) ? shadow_stack[n - 2] : '0;
            z = (n >= 1) ? shadow_stack[n - 1] : '0;
            case (c.func)
                FUNC_PUSH:
                begin
                    shadow_stack[n] = c.value;
                    n++;
                end
                FUNC_CLEAR: n = 0;
                FUNC_DUP:
                begin
                    shadow_stack[n] = z;
                    n++;
                end
                FUNC_DUPD:
                begin
                    shadow_stack[n]     = z;
                    shadow_stack[n - 1] = y;
                    n++;
                end
                FUNC_POP:  n--;
                FUNC_POPD:
                begin
                    shadow_stack[n - 2] = z;
                    n--;
                end
                FUNC_POP2: n -= 2;
                FUNC_SWAP:
                begin
                    shadow_stack[n - 2] = z;
                    shadow_stack[n - 1] = y;
                end
                FUNC_SWAPD:
                begin
                    shadow_stack[n - 3] = y;
                    shadow_stack[n - 2] = x;
                end
                FUNC_ROTATE:
                begin
                    shadow_stack[n - 3] = z;
                    shadow_stack[n - 1] = x;
                end
                FUNC_ROLLUP:
                begin
                    shadow_stack[n - 3] = z;
                    shadow_stack[n - 2] = x;
                    shadow_stack[n - 1] = y;
                end
                FUNC_ROLLDOWN:
                begin
                    shadow_stack[n - 3] = y;
                    shadow_stack[n - 2] = z;
                    shadow_stack[n - 1] = x;
                end
                default: ;
            endcase
        end
        shadow_depth = n;
        r.depth = CNT_W'(shadow_depth);
        r.top0  = shadow_entry(0);
        r.top1  = shadow_entry(1);
        r.top2  = shadow_entry(2);
        return r;
    endfunction

    // Draw one random operation, biased by the current drift mode
    function automatic cmd_t random_op(input drift_t mode);
        cmd_t        c;
        int unsigned grow_w, shrink_w, pick;
        grow_w   = (mode == MODE_GROW) ? 60 : (mode == MODE_SHRINK) ? 15 : 30;
        shrink_w = (mode == MODE_SHRINK) ? 45 : (mode == MODE_GROW) ? 10 : 25;
        pick     = $urandom_range(99);
        // Favor the extreme words now and then; a fresh value is drawn on every op
        case ($urandom_range(9))
            0: c.value = '0;
            1: c.value = '1;
            default: c.value = $urandom;
        endcase
        if (pick < 2)
        begin
            c.func = FUNC_CLEAR;
        end
        else if (pick < 5)
        begin
            c.func = FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        end
        else if (pick < 5 + grow_w)
        begin
            case ($urandom_range(4))
                0: c.func = FUNC_DUP;
                1: c.func = FUNC_DUPD;
                default: c.func = FUNC_PUSH;
            endcase
        end
        else if (pick < 5 + grow_w + shrink_w)
        begin
            c.func = FUNC_W'($urandom_range(FUNC_POP, FUNC_POP2));
        end
        else
        begin
            c.func = FUNC_W'($urandom_range(FUNC_SWAP, FUNC_ROLLDOWN));
        end
        return c;
    endfunction

    task automatic add_row(input logic [FUNC_W-1:0] func, input word_t value, input int reps,
                           input bit typed, input logic [STATUS_W-1:0] status,
                           input int depth, input word_t t0, input word_t t1, input word_t t2);
        dir_row_t row;
        row.func        = func;
        row.value       = value;
        row.reps        = reps;
        row.typed       = typed;
        row.want.status = status;
        row.want.depth  = CNT_W'(depth);
        row.want.top0   = t0;
        row.want.top1   = t1;
        row.want.top2   = t2;
        dir_rows.insert(dir_rows.size(), row);
    endtask

    // Offer one operation, starting and ending at a falling edge. Insert random
    // idle cycles first, then hold the payload until the transfer is taken and
    // queue the response it must produce.
    task automatic send_op(input cmd_t c, input bit typed, input rsp_t want);
        rsp_t pred;
        while (!quiet && $urandom_range(99) < IDLE_PERCENT)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        // Always advance the shadow stack, even when the row carries its own answer
        pred = apply_stack_op(c);
        expected_rsp_q.insert(expected_rsp_q.size(), typed ? want : pred);
        @(negedge clk);
    endtask

    // Stall the response side at random, except in the quiet window
    always @(negedge clk)
    begin
        rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
    end

    // Compare every response transfer with the oldest expectation, field by field
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                if (mismatches < REPORT_LIMIT)
                    $display("ERROR: unexpected rsp transfer: status %0d depth %0d top %h %h %h",
                             rsp.status, rsp.depth, rsp.top0, rsp.top1, rsp.top2);
                mismatches++;
            end
            else
            begin
                want = expected_rsp_q.pop_front();
                if (rsp.status !== want.status || rsp.depth !== want.depth ||
                    rsp.top0 !== want.top0 || rsp.top1 !== want.top1 || rsp.top2 !== want.top2)
                begin
                    if (mismatches < REPORT_LIMIT)
                    begin
                        $display("ERROR: rsp mismatch at cycle %0d", cycles);
                        $display("  expected status %0d depth %0d top %h %h %h",
                                 want.status, want.depth, want.top0, want.top1, want.top2);
                        $display("  actual   status %0d depth %0d top %h %h %h",
                                 rsp.status, rsp.depth, rsp.top0, rsp.top1, rsp.top2);
                    end
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run as failed once the cycle count reaches CYCLE_LIMIT
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        cmd_t   c;
        rsp_t   none;
        drift_t mode;
        int     run_left;
        none     = '0;
        mode     = MODE_MIXED;
        run_left = 0;

        // Directed table. Typed rows: operations on too short a stack, the extreme
        // words, a full stack refusing to grow, and clear. The rest go through
        // the shadow stack.
        add_row(FUNC_POP,     32'hDEAD_BEEF, 1, 1, STATUS_TOO_FEW, 0, '0, '0, '0);
        add_row(FUNC_DUP,     32'hDEAD_BEEF, 1, 1, STATUS_TOO_FEW, 0, '0, '0, '0);
        add_row(FUNC_ROLLDOWN, '0,           1, 1, STATUS_TOO_FEW, 0, '0, '0, '0);
        add_row(FUNC_PUSH,    '0,            1, 1, STATUS_OK, 1, '0, '0, '0);
        add_row(FUNC_PUSH,    '1,            1, 1, STATUS_OK, 2, '1, '0, '0);
        add_row(FUNC_SWAPD,   32'h0BAD_F00D, 1, 1, STATUS_TOO_FEW, 2, '1, '0, '0);
        add_row(FUNC_PUSH,    32'h1234_5678, 1, 0, STATUS_OK, 0, '0, '0, '0);
        add_row(FUNC_SWAP,    32'hDEAD_BEEF, 1, 0, STATUS_OK, 0, '0, '0, '0);
        add_row(FUNC_SWAPD,   '1,            1, 0, STATUS_OK, 0, '0, '0, '0);
        add_row(FUNC_ROTATE,  '0,            1, 0, STATUS_OK, 0, '0, '0, '0);
        add_row(FUNC_ROLLUP,  32'hDEAD_BEEF, 1, 0, STATUS_OK, 0, '0, '0, '0);
        add_row(FUNC_ROLLDOWN, 32'hDEAD_BEEF, 1, 0, STATUS_OK, 0, '0, '0, '0);
        add_row(FUNC_DUP,     '0,            1, 0, STATUS_OK, 0, '0, '0, '0);
        add_row(FUNC_DUPD,    '1,            1, 0, STATUS_OK, 0, '0, '0, '0);
        add_row(FUNC_POPD,    32'hDEAD_BEEF, 1, 0, STATUS_OK, 0, '0, '0, '0);
        add_row(FUNC_POP,     32'hDEAD_BEEF, 1, 0, STATUS_OK, 0, '0, '0, '0);
        add_row(FUNC_POP2,    32'hDEAD_BEEF, 1, 0, STATUS_OK, 0, '0, '0, '0);
        add_row(FUNC_SPARE_LO, '1,           1, 0, STATUS_OK, 0, '0, '0, '0);
        add_row(FUNC_SPARE_HI, '0,           1, 0, STATUS_OK, 0, '0, '0, '0);
        add_row(FUNC_CLEAR,   32'hDEAD_BEEF, 1, 1, STATUS_OK, 0, '0, '0, '0);
        // Fill to the brim with A5A50000, A5A50001, ...
        add_row(FUNC_PUSH,    32'hA5A5_0000, STACK_DEPTH, 0, STATUS_OK, 0, '0, '0, '0);
        add_row(FUNC_PUSH,    '1,            1, 1, STATUS_OVERFLOW, STACK_DEPTH,
                32'hA5A5_000F, 32'hA5A5_000E, 32'hA5A5_000D);
        add_row(FUNC_DUP,     '0,            1, 1, STATUS_OVERFLOW, STACK_DEPTH,
                32'hA5A5_000F, 32'hA5A5_000E, 32'hA5A5_000D);
        add_row(FUNC_DUPD,    '0,            1, 1, STATUS_OVERFLOW, STACK_DEPTH,
                32'hA5A5_000F, 32'hA5A5_000E, 32'hA5A5_000D);
        add_row(FUNC_ROLLUP,  '0,            1, 0, STATUS_OK, 0, '0, '0, '0);
        add_row(FUNC_CLEAR,   '0,            1, 1, STATUS_OK, 0, '0, '0, '0);

        // Hold reset, then release it at a falling edge
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table; a repeated push bumps its word each time
        foreach (dir_rows[i])
        begin
            for (int k = 0; k < dir_rows[i].reps; k++)
            begin
                c.func  = dir_rows[i].func;
                c.value = dir_rows[i].value + word_t'(k);
                send_op(c, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // Random streams: switch the drift mode every few dozen operations so
        // the stack swings between empty and full, with clears and spare codes mixed in
        for (int n = 0; n < RANDOM_OPS; n++)
        begin
            if (run_left == 0)
            begin
                mode     = drift_t'($urandom_range(MODE_MIXED));
                run_left = $urandom_range(20, 60);
            end
            run_left--;
            quiet = (n >= QUIET_FIRST) && (n < QUIET_LAST);
            send_op(random_op(mode), 1'b0, none);
        end
        cmd_valid <= 1'b0;

        // Drain: wait for every queued response, then keep watching for strays
        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
